@@ rtl/core/ksa_pkg.sv @@
// Package with the sizes, command codes and helpers of the shared-array stacks.
`default_nettype none

package ksa_pkg;

    localparam int SLOT_COUNT  = 64;
    localparam int STACK_COUNT = 8;

    localparam int CMD_W       = 2;
    localparam int ID_W        = 3;
    localparam int VALUE_W     = 32;

    localparam int ADDR_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LINK_W      = $clog2(SLOT_COUNT + 1);
    localparam int STACK_IDX_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int ENTRY_W     = LINK_W + VALUE_W;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOT_COUNT);

    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

    function automatic logic is_slot(input logic [LINK_W-1:0] p);
        return p < LINK_NULL;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ksa_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module ksa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/k_stacks_shared_array.sv @@
// Top level: several linked stacks and a free list sharing one slot memory.
// An accepted request sets r_busy; o_valid then strobes its registered result.
// No new request is taken while busy is high, during the read-modify-write of the link memory.
// Reset is synchronous: all stacks empty, free list starts at slot 0, no clearing pass.
// Slots never yet used are tracked by a fill count, so the link memory needs no init.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module k_stacks_shared_array (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ksa_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [ksa_pkg::ID_W-1:0]    i_stack_id,
    input  wire logic signed [ksa_pkg::VALUE_W-1:0] i_push_value,
    output logic                             o_valid,
    output logic                             o_ok,
    output logic                             o_stack_empty,
    output logic signed [ksa_pkg::VALUE_W-1:0] o_top_value
);

    // Each memory entry holds the link of a slot and the value of the slot it links to.
    logic                               r_busy;
    logic [ksa_pkg::CMD_W-1:0]          r_cmd;
    logic [ksa_pkg::ID_W-1:0]           r_sid;
    logic [ksa_pkg::VALUE_W-1:0]        r_val;
    logic [ksa_pkg::LINK_W-1:0]         r_head [ksa_pkg::STACK_COUNT];
    logic [ksa_pkg::VALUE_W-1:0]        r_top [ksa_pkg::STACK_COUNT];
    logic [ksa_pkg::LINK_W-1:0]         r_free;
    logic [ksa_pkg::LINK_W-1:0]         r_fill;

    logic                               accept;
    logic [ksa_pkg::LINK_W-1:0]         a_head;
    logic [ksa_pkg::ADDR_W-1:0]         rd_addr;
    logic [ksa_pkg::ENTRY_W-1:0]        rd_data;
    logic [ksa_pkg::LINK_W-1:0]         rd_link;
    logic [ksa_pkg::VALUE_W-1:0]        rd_val;

    logic [ksa_pkg::STACK_IDX_W-1:0]    w_idx;
    logic                               sid_ok;
    logic [ksa_pkg::LINK_W-1:0]         cur_head;
    logic [ksa_pkg::VALUE_W-1:0]        cur_top;

    logic                               wr_en;
    logic [ksa_pkg::ADDR_W-1:0]         wr_addr;
    logic [ksa_pkg::ENTRY_W-1:0]        wr_data;
    logic                               head_we;
    logic [ksa_pkg::LINK_W-1:0]         n_head;
    logic [ksa_pkg::VALUE_W-1:0]        n_top;
    logic [ksa_pkg::LINK_W-1:0]         n_free;
    logic [ksa_pkg::LINK_W-1:0]         n_fill;
    logic                               n_ok;
    logic                               n_empty;
    logic [ksa_pkg::VALUE_W-1:0]        n_top_value;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    assign a_head  = r_head[ksa_pkg::STACK_IDX_W'(i_stack_id)];
    assign rd_addr = (i_cmd == ksa_pkg::CMD_PUSH) ? r_free[ksa_pkg::ADDR_W-1:0]
                                                  : a_head[ksa_pkg::ADDR_W-1:0];

    ksa_ram #(
        .WIDTH (ksa_pkg::ENTRY_W),
        .DEPTH (ksa_pkg::SLOT_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (r_busy && wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_link = rd_data[ksa_pkg::ENTRY_W-1:ksa_pkg::VALUE_W];
    assign rd_val  = rd_data[ksa_pkg::VALUE_W-1:0];

    assign w_idx    = ksa_pkg::STACK_IDX_W'(r_sid);
    assign sid_ok   = 32'(r_sid) < ksa_pkg::STACK_COUNT;
    assign cur_head = r_head[w_idx];
    assign cur_top  = r_top[w_idx];

    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = r_free[ksa_pkg::ADDR_W-1:0];
        wr_data     = {cur_head, cur_top};
        head_we     = 1'b0;
        n_head      = cur_head;
        n_top       = cur_top;
        n_free      = r_free;
        n_fill      = r_fill;
        n_ok        = 1'b1;
        n_empty     = !ksa_pkg::is_slot(cur_head);
        n_top_value = ksa_pkg::is_slot(cur_head) ? cur_top : '1;
        if (!sid_ok) begin
            n_ok        = 1'b0;
            n_empty     = 1'b1;
            n_top_value = '1;
        end else begin
            unique case (r_cmd)
                ksa_pkg::CMD_PUSH: begin
                    if (ksa_pkg::is_slot(r_free)) begin
                        wr_en   = 1'b1;
                        wr_addr = r_free[ksa_pkg::ADDR_W-1:0];
                        wr_data = {cur_head, cur_top};
                        head_we = 1'b1;
                        n_head  = r_free;
                        n_top   = r_val;
                        if (r_free >= r_fill) begin
                            n_free = r_free + ksa_pkg::LINK_W'(1);
                            n_fill = r_free + ksa_pkg::LINK_W'(1);
                        end else begin
                            n_free = rd_link;
                        end
                        n_empty     = 1'b0;
                        n_top_value = r_val;
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                ksa_pkg::CMD_POP: begin
                    if (ksa_pkg::is_slot(cur_head)) begin
                        wr_en       = 1'b1;
                        wr_addr     = cur_head[ksa_pkg::ADDR_W-1:0];
                        wr_data     = {r_free, rd_val};
                        head_we     = 1'b1;
                        n_head      = rd_link;
                        n_top       = rd_val;
                        n_free      = cur_head;
                        n_empty     = !ksa_pkg::is_slot(rd_link);
                        n_top_value = ksa_pkg::is_slot(rd_link) ? rd_val : '1;
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
            r_free  <= '0;
            r_fill  <= '0;
            for (int k = 0; k < ksa_pkg::STACK_COUNT; k++) begin
                r_head[k] <= ksa_pkg::LINK_NULL;
            end
        end else begin
            r_busy  <= accept;
            o_valid <= r_busy;
            if (r_busy) begin
                r_free <= n_free;
                r_fill <= n_fill;
                if (head_we) begin
                    r_head[w_idx] <= n_head;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_sid <= i_stack_id;
            r_val <= i_push_value;
        end
        if (r_busy) begin
            if (head_we) begin
                r_top[w_idx] <= n_top;
            end
            o_ok          <= n_ok;
            o_stack_empty <= n_empty;
            o_top_value   <= n_top_value;
        end
    end

`ifndef SYNTHESIS
    a_one_work_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("Work cycle lasted more than one cycle.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_valid)
        else $error("Result strobe missing after a work cycle.");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= ksa_pkg::LINK_NULL) && (r_free <= ksa_pkg::LINK_NULL))
        else $error("Free head or fill count out of range.");

    a_free_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free >= r_fill) |-> ((r_free == r_fill) || (r_free == ksa_pkg::LINK_NULL)))
        else $error("Free list skipped an unused slot.");

    a_empty_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_empty) |-> (o_top_value == '1))
        else $error("Empty stack reported a top value other than all ones.");
`endif

endmodule

`default_nettype wire
